@@ sv/lss_pkg.sv @@
package lss_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int ERR_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH     = 3'd0,
        OP_POP      = 3'd1,
        OP_CLEAR    = 3'd2,
        OP_CONTAINS = 3'd3,
        OP_REMOVE   = 3'd4
    } t_op;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK        = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_OVERFLOW  = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SORT,
        S_DONE
    } t_state;

    // per-cell command, broadcast to the whole row
    typedef enum logic [2:0] {
        C_HOLD,
        C_PUSH,
        C_POP,
        C_MARK_FIND,
        C_MARK_DEL,
        C_SWAP
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd                 cmd;
        logic signed [DATA_W-1:0]  key;
    } t_cell_ctl;

    // what a cell shows its neighbors
    typedef struct packed {
        logic signed [DATA_W-1:0]  data;
        logic                      flag;
    } t_cell_link;

endpackage

@@ sv/lss_req_if.sv @@
interface lss_req_if;
    import lss_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, op, value, input ready);
    modport sink   (input valid, op, value, output ready);
endinterface

@@ sv/lss_rsp_if.sv @@
interface lss_rsp_if #(
    parameter int CNT_W = 5
);
    import lss_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_value;
    logic                     read_valid;
    logic                     found;
    logic [CNT_W-1:0]         entry_count;
    logic                     is_empty;
    logic [ERR_W-1:0]         error_code;

    modport source (output valid, read_value, read_valid, found, entry_count, is_empty,
                     error_code, input ready);
    modport sink   (input valid, read_value, read_valid, found, entry_count, is_empty,
                     error_code, output ready);
endinterface

@@ sv/lss_cell.sv @@
module lss_cell (
    input  logic                i_clk,
    input  lss_pkg::t_cell_ctl  i_ctl,
    input  logic                i_occ,
    input  logic                i_pair_lo,
    input  logic                i_pair_hi,
    input  lss_pkg::t_cell_link i_lower,
    input  lss_pkg::t_cell_link i_upper,
    output lss_pkg::t_cell_link o_link
);
    import lss_pkg::*;

    t_cell_link r_cell;
    t_cell_link n_cell;

    always_comb begin
        n_cell = r_cell;
        unique case (i_ctl.cmd)
            C_HOLD: begin
            end
            C_PUSH: begin
                n_cell.data = i_lower.data;
            end
            C_POP: begin
                n_cell.data = i_upper.data;
            end
            C_MARK_FIND: begin
                n_cell.flag = i_occ && (r_cell.data == i_ctl.key);
            end
            C_MARK_DEL: begin
                // flag marks a hole: empty slot or a copy to drop
                n_cell.flag = !i_occ || (r_cell.data == i_ctl.key);
            end
            C_SWAP: begin
                // move a kept entry one step toward the top, the hole one step away
                if (i_pair_lo && r_cell.flag && !i_upper.flag) begin
                    n_cell.data = i_upper.data;
                    n_cell.flag = 1'b0;
                end else if (i_pair_hi && i_lower.flag && !r_cell.flag) begin
                    n_cell.flag = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_link = r_cell;

endmodule

@@ sv/lifo_stack_with_search_unit.sv @@
// Push, pop, clear and unused codes: result registered in the cycle after the input transfer;
// one item per cycle while the result side keeps taking.
// Contains: mark pass in every cell, then OR over the match flags.
// Remove: mark pass, then the odd-even compaction pass over the cell row.
// Reset (synchronous, active low) empties the stack and drops any pending result;
// entry data is not cleared.
module lifo_stack_with_search_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lss_req_if.sink       i_req,
    lss_rsp_if.source     o_rsp
);
    import lss_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_phase, n_phase;
    logic                     r_del, n_del;
    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_rd_value, n_rd_value;
    logic                     r_rd_valid, n_rd_valid;
    logic                     r_found, n_found;
    logic [CNT_W-1:0]         r_out_cnt, n_out_cnt;
    t_err                     r_err, n_err;

    t_cell_ctl                w_ctl;
    t_cell_link               w_link [STACK_DEPTH];
    logic [STACK_DEPTH-1:0]   w_occ;
    logic [STACK_DEPTH-1:0]   w_lo;
    logic [STACK_DEPTH-1:0]   w_hi;
    logic [STACK_DEPTH-1:0]   w_edge;
    logic [STACK_DEPTH-1:0]   w_flag;
    logic [CNT_W-1:0]         w_kept;
    logic                     w_in_ready;
    logic                     w_in_fire;
    logic                     w_has_top;

    assign w_in_ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_in_fire  = i_req.valid && w_in_ready;
    assign w_has_top  = (r_count != '0);

    // cell 0 holds the top of stack
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        localparam logic PAR = 1'(g % 2);
        t_cell_link w_lower;
        t_cell_link w_upper;

        if (g == 0) begin : g_bot
            assign w_lower = '{data: i_req.value, flag: 1'b0};
        end else begin : g_mid
            assign w_lower = w_link[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_next
            assign w_upper = w_link[g+1];
        end

        assign w_occ[g]  = CNT_W'(g) < r_count;
        assign w_lo[g]   = (g < STACK_DEPTH - 1) && (r_phase[0] == PAR);
        assign w_hi[g]   = (g > 0) && (r_phase[0] != PAR);
        assign w_flag[g] = w_link[g].flag;
        // last kept entry: everything above it is a hole
        assign w_edge[g] = !w_link[g].flag && ((g == STACK_DEPTH - 1) || w_upper.flag);

        lss_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_occ     (w_occ[g]),
            .i_pair_lo (w_lo[g]),
            .i_pair_hi (w_hi[g]),
            .i_lower   (w_lower),
            .i_upper   (w_upper),
            .o_link    (w_link[g])
        );
    end

    always_comb begin
        w_kept = '0;
        for (int i = 0; i < STACK_DEPTH; i++) begin
            if (w_edge[i]) begin
                w_kept = w_kept | CNT_W'(i + 1);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (i_req.op == OP_REMOVE) begin
                        n_state = S_SORT;
                    end else if (i_req.op == OP_CONTAINS) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SORT: begin
                if (r_phase == CNT_W'(STACK_DEPTH - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath control and result
    always_comb begin
        logic [CNT_W-1:0] v_cnt;
        v_cnt       = r_count;
        w_ctl.cmd   = C_HOLD;
        w_ctl.key   = i_req.value;
        n_count     = r_count;
        n_phase     = r_phase;
        n_del       = r_del;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_rd_value  = r_rd_value;
        n_rd_valid  = r_rd_valid;
        n_found     = r_found;
        n_out_cnt   = r_out_cnt;
        n_err       = r_err;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_found = 1'b0;
                    n_err   = ERR_OK;
                    unique case (i_req.op)
                        OP_PUSH: begin
                            if (r_count < CNT_W'(STACK_DEPTH)) begin
                                w_ctl.cmd   = C_PUSH;
                                n_count     = r_count + CNT_W'(1);
                                n_out_valid = 1'b1;
                                n_rd_value  = i_req.value;
                                n_rd_valid  = 1'b1;
                                n_out_cnt   = r_count + CNT_W'(1);
                            end else begin
                                n_out_valid = 1'b1;
                                n_rd_value  = w_link[0].data;
                                n_rd_valid  = 1'b1;
                                n_out_cnt   = r_count;
                                n_err       = ERR_OVERFLOW;
                            end
                        end
                        OP_POP: begin
                            n_out_valid = 1'b1;
                            if (w_has_top) begin
                                w_ctl.cmd  = C_POP;
                                n_count    = r_count - CNT_W'(1);
                                n_rd_value = w_link[0].data;
                                n_rd_valid = 1'b1;
                                n_out_cnt  = r_count - CNT_W'(1);
                            end else begin
                                n_rd_value = '0;
                                n_rd_valid = 1'b0;
                                n_out_cnt  = '0;
                                n_err      = ERR_UNDERFLOW;
                            end
                        end
                        OP_CLEAR: begin
                            n_count     = '0;
                            n_out_valid = 1'b1;
                            n_rd_value  = '0;
                            n_rd_valid  = 1'b0;
                            n_out_cnt   = '0;
                        end
                        OP_CONTAINS: begin
                            w_ctl.cmd = C_MARK_FIND;
                            n_del     = 1'b0;
                        end
                        OP_REMOVE: begin
                            w_ctl.cmd = C_MARK_DEL;
                            n_del     = 1'b1;
                            n_phase   = '0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_rd_value  = w_has_top ? w_link[0].data : '0;
                            n_rd_valid  = w_has_top;
                            n_out_cnt   = r_count;
                        end
                    endcase
                end
            end
            S_SORT: begin
                w_ctl.cmd = C_SWAP;
                n_phase   = r_phase + CNT_W'(1);
            end
            S_DONE: begin
                v_cnt       = r_del ? w_kept : r_count;
                n_count     = v_cnt;
                n_out_valid = 1'b1;
                n_rd_value  = (v_cnt != '0) ? w_link[0].data : '0;
                n_rd_valid  = (v_cnt != '0);
                n_found     = !r_del && (|w_flag);
                n_out_cnt   = v_cnt;
                n_err       = ERR_OK;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_phase     <= '0;
            r_del       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_phase     <= n_phase;
            r_del       <= n_del;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_value <= n_rd_value;
        r_rd_valid <= n_rd_valid;
        r_found    <= n_found;
        r_out_cnt  <= n_out_cnt;
        r_err      <= n_err;
    end

    assign i_req.ready       = w_in_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_value  = r_rd_value;
    assign o_rsp.read_valid  = r_rd_valid;
    assign o_rsp.found       = r_found;
    assign o_rsp.entry_count = r_out_cnt;
    assign o_rsp.is_empty    = (r_out_cnt == '0);
    assign o_rsp.error_code  = r_err;

endmodule

@@ sv/lss_chk.sv @@
module lss_chk #(
    parameter int STACK_DEPTH = 16,
    parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [31:0]       i_read_value,
    input logic              i_read_valid,
    input logic              i_found,
    input logic [CNT_W-1:0]  i_entry_count,
    input logic              i_is_empty,
    input logic [1:0]        i_error_code
);
    import lss_pkg::*;

    // a stalled result holds until the transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_read_value, i_read_valid, i_found, i_entry_count, i_error_code}))
        else $error("result changed while stalled");

    // never take an item while an untaken result blocks the output register
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !i_out_valid || i_out_ready)
        else $error("input taken while result pending");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_is_empty == (i_entry_count == '0))
        else $error("empty flag disagrees with count");

    a_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_error_code == ERR_UNDERFLOW |-> !i_read_valid && i_is_empty && !i_found)
        else $error("bad underflow result");

    a_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_error_code == ERR_OVERFLOW
            |-> i_read_valid && i_entry_count == CNT_W'(STACK_DEPTH))
        else $error("bad overflow result");

endmodule

bind lifo_stack_with_search_unit lss_chk #(.STACK_DEPTH(STACK_DEPTH)) u_lss_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_read_value  (o_rsp.read_value),
    .i_read_valid  (o_rsp.read_valid),
    .i_found       (o_rsp.found),
    .i_entry_count (o_rsp.entry_count),
    .i_is_empty    (o_rsp.is_empty),
    .i_error_code  (o_rsp.error_code)
);
